[hdl/tscat_pkg.sv]
// Shared types, constants and codes for the CA table section parser.
package tscat_pkg;

	localparam int PAYLOAD_MAX_DEF     = 184;
	localparam int MAX_DESCRIPTORS_DEF = 16;

	localparam logic [7:0]  TABLE_ID_CAT  = 8'h01;
	localparam logic [12:0] TABLE_PID_RST = 13'd1;
	localparam logic [11:0] SECTION_MIN   = 12'd9;
	localparam logic [7:0]  DESC_LEN_MIN  = 8'd4;

	typedef enum logic [1:0] {
		KIND_DESC_HDR = 2'd0,
		KIND_PRIVATE  = 2'd1,
		KIND_PARSE    = 2'd2,
		KIND_CHANGE   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TABLE_ID = 3'd1,
		ST_SPAN     = 3'd2,
		ST_SECNUM   = 3'd3,
		ST_MULTI    = 3'd4,
		ST_DESC     = 3'd5
	} status_t;

	typedef enum logic {
		OP_PARSE   = 1'b0,
		OP_COMPARE = 1'b1
	} op_t;

	typedef struct packed {
		logic        opcode;
		logic [12:0] packet_pid;
		logic        scrambled;
		logic [7:0]  payload_length;
		logic [7:0]  payload_byte;
		logic        first_byte;
		logic        last_byte;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  descriptor_tag;
		logic [15:0] ca_system_id;
		logic [12:0] ca_pid;
		logic [7:0]  private_length;
		logic [7:0]  private_byte;
		logic [2:0]  parse_status;
		logic [4:0]  version;
		logic        current_next;
		logic [4:0]  descriptor_count;
		logic        changed;
		logic        last_result;
	} out_t;

	// item as queued between front and back (PID already matched)
	typedef struct packed {
		logic       opcode;
		logic [7:0] payload_length;
		logic [7:0] payload_byte;
		logic       first_byte;
		logic       last_byte;
	} item_t;

	// front to back queue handshake
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

endpackage

[hdl/tscat_ram.sv]
// Generic single write port RAM with registered read.
module tscat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 368
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/tscat_front.sv]
// Front end: input accept, PID/scrambling filter and two-entry queue.
module tscat_front import tscat_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_table_pid,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output queue_out_t  q_out,
	input  logic        q_pop
);

	logic [12:0] table_pid_q;
	item_t       fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        push, pop;

	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_pid_q <= TABLE_PID_RST;
		end else if (cfg_valid) begin
			table_pid_q <= cfg_table_pid;
		end
	end

	// classify: only clear packets on the table PID are queued
	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready &&
	                  (in_data.packet_pid == table_pid_q) && !in_data.scrambled;
	assign pop      = q_pop && (count_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{opcode: in_data.opcode,
			                      payload_length: in_data.payload_length,
			                      payload_byte: in_data.payload_byte,
			                      first_byte: in_data.first_byte,
			                      last_byte: in_data.last_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign q_out.valid = (count_q != 2'd0);
	assign q_out.item  = fifo_q[rd_ptr_q];

endmodule

[hdl/tscat_back.sv]
// Back end: section parse state, payload store, compare and result output.
module tscat_back import tscat_pkg::*; #(
	parameter int PAYLOAD_MAX     = PAYLOAD_MAX_DEF,
	parameter int MAX_DESCRIPTORS = MAX_DESCRIPTORS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  queue_out_t q_in,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output out_t       out_data
);

	localparam int DEPTH = 2 * PAYLOAD_MAX;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(MAX_DESCRIPTORS + 1);
	localparam logic [7:0]    PMAX = 8'(PAYLOAD_MAX);
	localparam logic [FW-1:0] DMAX = FW'(MAX_DESCRIPTORS);

	typedef struct packed {
		out_t       r0;
		out_t       r1;
		logic [1:0] cnt;
		logic       cmp_act;
		logic       do_cmp;
		logic       forced;
		logic       first;
		logic [7:0] b;
	} s2_t;

	// parse state
	logic [7:0]    pos_q, ptr_q, didx_q, dlen_q, tidx_q, clen_q;
	logic [11:0]   sl_q;
	logic [31:0]   hdr_q;
	logic [4:0]    ver_q;
	logic          cn_q, cbank_q, open_q, done_q, diff_q;
	logic [FW-1:0] found_q;
	logic [2:0]    err_q;

	logic [7:0]    n_pos, n_ptr, n_didx, n_dlen, n_tidx, n_clen, t, d;
	logic [11:0]   n_sl, sl;
	logic [31:0]   n_hdr;
	logic [4:0]    n_ver;
	logic          n_cn, n_cbank, n_open, n_done, dec, ok;
	logic [FW-1:0] n_found;
	logic [2:0]    n_err;
	out_t          desc_r, stat_r;
	logic          desc_emit;
	s2_t           s1_res;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    rdata;

	s2_t  s2_data;
	logic s2_valid, s2_idx_q, s2_done, diff_new;

	tscat_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(q_in.item.payload_byte),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	// stage 1: per-byte parse and store access
	always_comb begin
		n_pos = pos_q; n_ptr = ptr_q; n_didx = didx_q; n_dlen = dlen_q;
		n_tidx = tidx_q; n_clen = clen_q; n_sl = sl_q; n_hdr = hdr_q;
		n_ver = ver_q; n_cn = cn_q; n_cbank = cbank_q; n_open = open_q;
		n_done = done_q; n_found = found_q; n_err = err_q;
		t = '0; d = '0; sl = '0; dec = 1'b0; ok = 1'b0;
		desc_r = '0; stat_r = '0; desc_emit = 1'b0; s1_res = '0;
		we = 1'b0; re = 1'b0; waddr = '0; raddr = '0;
		s1_res.b     = q_in.item.payload_byte;
		s1_res.first = q_in.item.first_byte;

		if (q_in.item.first_byte) begin
			n_pos = '0; n_ptr = '0; n_sl = '0; n_didx = '0; n_dlen = '0;
			n_hdr = '0; n_ver = '0; n_cn = 1'b0; n_found = '0; n_err = ST_OK;
			n_done = 1'b0; n_tidx = '0; n_open = 1'b1;
		end

		if (n_open) begin
			if (q_in.item.opcode == OP_PARSE) begin
				if (n_pos < PMAX) begin
					we    = q_pop;
					waddr = cbank_q ? AW'(PAYLOAD_MAX) + AW'(n_pos) : AW'(n_pos);
					if (n_err == ST_OK && !n_done) begin
						if (n_pos == 8'd0) begin
							n_ptr = q_in.item.payload_byte;
						end else if (n_ptr != 8'd0) begin
							n_ptr = n_ptr - 8'd1;
						end else begin
							t = n_tidx;
							if (n_tidx != 8'hFF) n_tidx = n_tidx + 8'd1;
							if (t == 8'd0) begin
								if (q_in.item.payload_byte != TABLE_ID_CAT) n_err = ST_TABLE_ID;
							end else if (t == 8'd1) begin
								n_hdr = {24'd0, q_in.item.payload_byte};
							end else if (t == 8'd2) begin
								sl   = {n_hdr[3:0], q_in.item.payload_byte};
								n_sl = sl;
								if ({5'd0, n_pos} + 13'd1 + {1'b0, sl} >
								    {5'd0, q_in.item.payload_length})
									n_err = ST_SPAN;
								else if (sl < SECTION_MIN)
									n_err = ST_DESC;
							end else begin
								dec = 1'b1;
								if (t == 8'd5) begin
									n_ver = q_in.item.payload_byte[5:1];
									n_cn  = q_in.item.payload_byte[0];
								end else if (t == 8'd6) begin
									if (q_in.item.payload_byte != 8'd0) begin
										n_err = ST_SECNUM; dec = 1'b0;
									end
								end else if (t == 8'd7) begin
									if (q_in.item.payload_byte != 8'd0) begin
										n_err = ST_MULTI; dec = 1'b0;
									end
								end else if (t >= 8'd8 && (n_didx != 8'd0 || n_sl > 12'd4)) begin
									// CA descriptor bytes
									d  = n_didx;
									ok = 1'b1;
									if (d == 8'd0) begin
										if (n_found >= DMAX) begin
											n_err = ST_DESC; ok = 1'b0;
										end else begin
											n_hdr = {q_in.item.payload_byte, 24'd0};
										end
									end else if (d == 8'd1) begin
										if (q_in.item.payload_byte < DESC_LEN_MIN ||
										    {4'd0, q_in.item.payload_byte} + 12'd5 > n_sl) begin
											n_err = ST_DESC; ok = 1'b0;
										end else begin
											n_dlen = q_in.item.payload_byte;
										end
									end else if (d == 8'd2) begin
										n_hdr[23:16] = q_in.item.payload_byte;
									end else if (d == 8'd3) begin
										n_hdr[15:8] = q_in.item.payload_byte;
									end else if (d == 8'd4) begin
										n_hdr[7:0] = q_in.item.payload_byte;
									end else if (d == 8'd5) begin
										desc_emit             = 1'b1;
										desc_r.kind           = KIND_DESC_HDR;
										desc_r.descriptor_tag = n_hdr[31:24];
										desc_r.ca_system_id   = n_hdr[23:8];
										desc_r.ca_pid         = {n_hdr[4:0], q_in.item.payload_byte};
										desc_r.private_length = n_dlen - DESC_LEN_MIN;
									end else begin
										desc_emit             = 1'b1;
										desc_r.kind           = KIND_PRIVATE;
										desc_r.descriptor_tag = n_hdr[31:24];
										desc_r.private_byte   = q_in.item.payload_byte;
									end
									if (ok) begin
										d = d + 8'd1;
										if (d >= 8'd2 && {1'b0, d} == {1'b0, n_dlen} + 9'd2) begin
											d       = 8'd0;
											n_found = n_found + FW'(1);
										end
										n_didx = d;
									end else begin
										dec = 1'b0;
									end
								end
								if (dec) begin
									if (n_sl != 12'd0) n_sl = n_sl - 12'd1;
									if (n_sl == 12'd0) n_done = 1'b1;
								end
							end
						end
					end
				end
			end else begin
				// compare against the committed bank
				s1_res.cmp_act = 1'b1;
				s1_res.do_cmp  = (n_pos < clen_q) && (n_pos < PMAX);
				s1_res.forced  = !s1_res.do_cmp;
				re    = s1_res.do_cmp && q_pop;
				raddr = cbank_q ? AW'(n_pos) : AW'(PAYLOAD_MAX) + AW'(n_pos);
			end

			if (n_pos < PMAX) n_pos = n_pos + 8'd1;

			if (q_in.item.last_byte) begin
				if (q_in.item.opcode == OP_PARSE) begin
					if (n_err == ST_OK && !n_done) n_err = ST_SPAN;
					if (n_err == ST_OK) begin
						n_cbank = ~cbank_q;
						n_clen  = n_pos;
					end
					stat_r.kind             = KIND_PARSE;
					stat_r.parse_status     = n_err;
					stat_r.version          = n_ver;
					stat_r.current_next     = n_cn;
					stat_r.descriptor_count = 5'(n_found);
				end else begin
					stat_r.kind = KIND_CHANGE;
					if (n_pos != clen_q || q_in.item.payload_length != clen_q)
						s1_res.forced = 1'b1;
				end
				stat_r.last_result = 1'b1;
				n_open = 1'b0;
			end
		end

		// pack results in order
		if (desc_emit) begin
			s1_res.r0 = desc_r;
			if (q_in.item.last_byte && n_open == 1'b0 && open_or_first()) begin
				s1_res.r1  = stat_r;
				s1_res.cnt = 2'd2;
			end else begin
				s1_res.r0.last_result = 1'b1;
				s1_res.cnt = 2'd1;
			end
		end else if (stat_r.last_result) begin
			s1_res.r0  = stat_r;
			s1_res.cnt = 2'd1;
		end
	end

	function automatic logic open_or_first();
		return open_q || q_in.item.first_byte;
	endfunction

	// stage 2 retire and stage 1 advance
	assign s2_done = s2_valid &&
	                 (s2_data.cnt == 2'd0 ||
	                  (out_ready && {1'b0, s2_idx_q} == s2_data.cnt - 2'd1));
	assign q_pop   = q_in.valid && (!s2_valid || s2_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; ptr_q <= '0; didx_q <= '0; dlen_q <= '0; tidx_q <= '0;
			clen_q <= '0; sl_q <= '0; hdr_q <= '0; ver_q <= '0; cn_q <= 1'b0;
			cbank_q <= 1'b0; open_q <= 1'b0; done_q <= 1'b0; found_q <= '0;
			err_q <= ST_OK;
		end else if (q_pop) begin
			pos_q <= n_pos; ptr_q <= n_ptr; didx_q <= n_didx; dlen_q <= n_dlen;
			tidx_q <= n_tidx; clen_q <= n_clen; sl_q <= n_sl; hdr_q <= n_hdr;
			ver_q <= n_ver; cn_q <= n_cn; cbank_q <= n_cbank; open_q <= n_open;
			done_q <= n_done; found_q <= n_found; err_q <= n_err;
		end
	end

	// stage 2 register
	always_ff @(posedge clk) begin
		if (q_pop) s2_data <= s1_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
			s2_idx_q <= 1'b0;
			diff_q   <= 1'b0;
		end else begin
			if (q_pop)        s2_valid <= 1'b1;
			else if (s2_done) s2_valid <= 1'b0;
			if (s2_done)                         s2_idx_q <= 1'b0;
			else if (out_valid && out_ready)     s2_idx_q <= 1'b1;
			if (s2_done) diff_q <= diff_new;
		end
	end

	// change flag from the stored byte read in stage 1
	always_comb begin
		diff_new = (s2_data.first ? 1'b0 : diff_q) |
		           (s2_data.cmp_act & (s2_data.forced |
		                               (s2_data.do_cmp & (rdata != s2_data.b))));
		out_data = s2_idx_q ? s2_data.r1 : s2_data.r0;
		if (out_data.kind == KIND_CHANGE) out_data.changed = diff_new;
	end

	assign out_valid = s2_valid && (s2_data.cnt != 2'd0);

endmodule

[hdl/ts_cat_section_parser_unit.sv]
// Top level of the CA table section parser.
// Takes one payload byte per cycle on the in channel and, while out_ready is
// high, accepts a byte every cycle; a byte that closes a descriptor-bearing
// packet can yield two results and holds the output stage until both are sent.
// The front filters on table_pid and queues up to two bytes; the back parses
// the section and reads or writes the two-bank payload store, whose registered
// read gives compare results in the cycle after the byte leaves the queue.
// The store needs no clearing after reset. table_pid is written on cfg.
module ts_cat_section_parser_unit import tscat_pkg::*; #(
	parameter int PAYLOAD_MAX     = PAYLOAD_MAX_DEF,
	parameter int MAX_DESCRIPTORS = MAX_DESCRIPTORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] cfg_table_pid,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data
);

	queue_out_t q;
	logic       q_pop;

	tscat_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_table_pid(cfg_table_pid),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_out(q), .q_pop(q_pop)
	);

	tscat_back #(
		.PAYLOAD_MAX(PAYLOAD_MAX), .MAX_DESCRIPTORS(MAX_DESCRIPTORS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_in(q), .q_pop(q_pop),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

[bench/ts_cat_section_parser_unit_tb.sv]
// Self-checking testbench for the CA table section parser: random and directed packets.
`timescale 1ns / 1ps

module ts_cat_section_parser_unit_tb;
	import tscat_pkg::*;

	localparam int PMAX = PAYLOAD_MAX_DEF;
	localparam int DMAX = MAX_DESCRIPTORS_DEF;
	localparam int CYCLE_LIMIT = 1500000;

	// Scoreboard: predicts results of accepted bytes and checks the output stream
	class cat_scoreboard;
		logic [12:0] pid_reg;
		logic [7:0]  pos, skip_left, desc_idx, desc_len, tbl_idx, commit_len;
		logic [11:0] sec_left;
		logic [31:0] hdr;
		logic [4:0]  ver, ndesc;
		logic        cn, commit_bank, diff, pkt_open, sec_done;
		logic [2:0]  err;
		logic [7:0]  store [2*PMAX];
		out_t        pending_results [$];
		int          errors;

		function new();
			errors = 0;
			pid_reg = TABLE_PID_RST;
			pos = 0; skip_left = 0; sec_left = 0; desc_idx = 0; desc_len = 0;
			hdr = 0; ver = 0; cn = 0; ndesc = 0; err = ST_OK;
			commit_bank = 0; commit_len = 0; diff = 0;
			pkt_open = 0; sec_done = 0; tbl_idx = 0;
			foreach (store[i]) store[i] = 0;
		endfunction

		function void push(out_t r);
			pending_results.push_back(r);
		endfunction

		// descriptor header and private byte handling
		function void desc_byte(logic [7:0] b, logic [11:0] left, ref int nres);
			out_t r;
			logic [7:0] d;
			d = desc_idx;
			if (d == 0) begin
				if (ndesc >= DMAX) begin err = ST_DESC; return; end
				hdr = {b, 24'h0};
			end else if (d == 1) begin
				if (b < DESC_LEN_MIN || 32'(b) + 5 > 32'(left)) begin
					err = ST_DESC;
					return;
				end
				desc_len = b;
			end else if (d == 2) begin
				hdr[23:16] = b;
			end else if (d == 3) begin
				hdr[15:8] = b;
			end else if (d == 4) begin
				hdr[7:0] = b;
			end else if (d == 5) begin
				r = '0;
				r.kind = KIND_DESC_HDR;
				r.descriptor_tag = hdr[31:24];
				r.ca_system_id = hdr[23:8];
				r.ca_pid = {hdr[4:0], b};
				r.private_length = desc_len - 8'd4;
				push(r); nres++;
			end else begin
				r = '0;
				r.kind = KIND_PRIVATE;
				r.descriptor_tag = hdr[31:24];
				r.private_byte = b;
				push(r); nres++;
			end
			d++;
			if (d >= 2 && 32'(d) == 32'(desc_len) + 2) begin
				d = 0;
				ndesc++;
			end
			desc_idx = d;
		endfunction

		function void parse(logic [7:0] b, logic [7:0] plen, ref int nres);
			logic [7:0] t;
			logic [11:0] sl, left;
			if (err != ST_OK || sec_done) return;
			if (pos == 0) begin skip_left = b; return; end
			if (skip_left != 0) begin skip_left--; return; end
			t = tbl_idx;
			if (tbl_idx < 255) tbl_idx++;
			if (t == 0) begin
				if (b != TABLE_ID_CAT) err = ST_TABLE_ID;
				return;
			end
			if (t == 1) begin hdr = {24'h0, b}; return; end
			if (t == 2) begin
				sl = {hdr[3:0], b};
				sec_left = sl;
				if (32'(pos) + 1 + 32'(sl) > 32'(plen)) err = ST_SPAN;
				else if (sl < SECTION_MIN) err = ST_DESC;
				return;
			end
			left = sec_left;
			if (t == 5) begin
				ver = b[5:1];
				cn = b[0];
			end else if (t == 6) begin
				if (b != 0) begin err = ST_SECNUM; return; end
			end else if (t == 7) begin
				if (b != 0) begin err = ST_MULTI; return; end
			end else if (t >= 8 && (desc_idx != 0 || left > 4)) begin
				desc_byte(b, left, nres);
				if (err != ST_OK) return;
			end
			if (sec_left > 0) sec_left--;
			if (sec_left == 0) sec_done = 1;
		endfunction

		// Note an accepted input byte; returns the number of results it causes
		function int note_input(in_t x);
			int nres;
			logic wb;
			out_t r;
			nres = 0;
			if (x.packet_pid != pid_reg || x.scrambled) return 0;
			if (x.first_byte) begin
				pos = 0; skip_left = 0; sec_left = 0; desc_idx = 0; desc_len = 0;
				hdr = 0; ver = 0; cn = 0; ndesc = 0; err = ST_OK; diff = 0;
				sec_done = 0; tbl_idx = 0; pkt_open = 1;
			end
			if (!pkt_open) return 0;
			wb = ~commit_bank;
			if (x.opcode == OP_PARSE) begin
				if (pos < PMAX) begin
					store[int'(wb) * PMAX + pos] = x.payload_byte;
					parse(x.payload_byte, x.payload_length, nres);
				end
			end else begin
				if (pos < commit_len && pos < PMAX) begin
					if (store[int'(commit_bank) * PMAX + pos] != x.payload_byte) diff = 1;
				end else begin
					diff = 1;
				end
			end
			if (pos < PMAX) pos++;
			if (x.last_byte) begin
				r = '0;
				if (x.opcode == OP_PARSE) begin
					if (err == ST_OK && !sec_done) err = ST_SPAN;
					if (err == ST_OK) begin
						commit_bank = wb;
						commit_len = pos;
					end
					r.kind = KIND_PARSE;
					r.parse_status = err;
					r.version = ver;
					r.current_next = cn;
					r.descriptor_count = ndesc;
				end else begin
					if (pos != commit_len || x.payload_length != commit_len) diff = 1;
					r.kind = KIND_CHANGE;
					r.changed = diff;
				end
				push(r); nres++;
				pkt_open = 0;
			end
			if (nres > 0)
				pending_results[pending_results.size() - 1].last_result = 1'b1;
			return nres;
		endfunction

		// Compare an accepted result with the oldest expectation
		function void check_result(out_t got);
			out_t exp;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			if (got !== exp) begin
				$display("%0t: result mismatch expected %h actual %h", $time, exp, got);
				if (got.kind !== exp.kind)
					$display("%0t:  kind expected %0d actual %0d", $time, exp.kind, got.kind);
				if (got.parse_status !== exp.parse_status)
					$display("%0t:  status expected %0d actual %0d", $time,
						exp.parse_status, got.parse_status);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        cfg_valid, cfg_ready;
	logic [12:0] cfg_table_pid;
	logic        in_valid, in_ready;
	in_t         in_data;
	logic        out_valid, out_ready;
	out_t        out_data;

	cat_scoreboard sb;
	int          cycle_count;
	int          items_sent;
	bit          stim_done;
	bit          rx_stall_en;
	logic [12:0] cur_pid;

	ts_cat_section_parser_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_table_pid(cfg_table_pid),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: random stalls, checks on each transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	initial begin : rx_proc
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			gap = rx_stall_en ? $urandom_range(0, 12) : 0;
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap > 0) begin
				out_ready <= 0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// Send one byte transaction, after a random idle gap unless no_gap is set
	task automatic send_byte(in_t x, bit no_gap);
		int gap, n;
		gap = no_gap ? 0 : $urandom_range(0, 12);
		if (!no_gap && $urandom_range(0, 2) != 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n = sb.note_input(x);
		items_sent++;
	endtask

	task automatic wait_drain();
		in_valid <= 0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_pid(logic [12:0] v);
		wait_drain();
		cfg_valid <= 1;
		cfg_table_pid <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.pid_reg = v;
		cfg_valid <= 0;
		cur_pid = v;
	endtask

	// Send a whole packet of bytes
	task automatic send_packet(logic [7:0] bytes [$], logic [7:0] plen, op_t op,
			logic [12:0] pid, bit scr, bit burst);
		in_t x;
		for (int i = 0; i < bytes.size(); i++) begin
			x.opcode = op;
			x.packet_pid = pid;
			x.scrambled = scr;
			x.payload_length = plen;
			x.payload_byte = bytes[i];
			x.first_byte = (i == 0);
			x.last_byte = (i == bytes.size() - 1);
			send_byte(x, burst);
		end
	endtask

	// Build a well-formed CAT section payload with random descriptors
	function automatic void build_section(ref logic [7:0] p [$], input int ndesc,
			input int maxpriv, input int ptr);
		logic [7:0] body [$];
		int len, dl;
		for (int d = 0; d < ndesc; d++) begin
			dl = 4 + $urandom_range(0, maxpriv);
			body.push_back(8'($urandom_range(0, 255)));
			body.push_back(8'(dl));
			for (int k = 0; k < dl; k++) body.push_back(8'($urandom_range(0, 255)));
		end
		len = 5 + body.size() + 4;
		p.delete();
		p.push_back(8'(ptr));
		for (int k = 0; k < ptr; k++) p.push_back(8'($urandom_range(0, 255)));
		p.push_back(TABLE_ID_CAT);
		p.push_back({4'($urandom_range(0, 15)), 4'(len >> 8)});
		p.push_back(len[7:0]);
		p.push_back(8'($urandom_range(0, 255)));
		p.push_back(8'($urandom_range(0, 255)));
		p.push_back(8'($urandom_range(0, 255)));
		p.push_back(8'h00);
		p.push_back(8'h00);
		foreach (body[k]) p.push_back(body[k]);
		for (int k = 0; k < 4; k++) p.push_back(8'($urandom_range(0, 255)));
	endfunction

	task automatic run_random(int target);
		logic [7:0] p [$];
		logic [7:0] last_good [$];
		logic [7:0] plen;
		int sel, pad, idx;
		bit burst;
		while (items_sent < target) begin
			sel = $urandom_range(0, 99);
			burst = ($urandom_range(0, 4) == 0);
			build_section(p, $urandom_range(0, 4), $urandom_range(0, 6),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 4) : 0);
			pad = $urandom_range(0, 3);
			for (int k = 0; k < pad; k++) p.push_back(8'hFF);
			plen = 8'(p.size());
			if (sel < 45) begin
				send_packet(p, plen, OP_PARSE, cur_pid, 0, burst);
				last_good = p;
			end else if (sel < 65 && last_good.size() > 0) begin
				p = last_good;
				plen = 8'(p.size());
				if ($urandom_range(0, 1)) p[$urandom_range(0, p.size() - 1)] ^= 8'h10;
				if ($urandom_range(0, 4) == 0) plen = plen + 8'd1;
				send_packet(p, plen, OP_COMPARE, cur_pid, 0, burst);
			end else if (sel < 80) begin
				// broken section: corrupt one byte and sometimes the length
				idx = $urandom_range(0, p.size() - 1);
				p[idx] = 8'($urandom_range(0, 255));
				if ($urandom_range(0, 2) == 0) plen = 8'($urandom_range(1, 255));
				send_packet(p, plen, op_t'($urandom_range(0, 1)), cur_pid, 0, burst);
			end else if (sel < 90) begin
				// scrambled, some also on another PID: ignored
				send_packet(p, plen, OP_PARSE,
					$urandom_range(0, 1) ? cur_pid ^ 13'($urandom_range(1, 8191)) : cur_pid,
					1, burst);
			end else begin
				// raw noise bytes with random flags and fields
				in_t x;
				for (int k = 0; k < 8; k++) begin
					x = in_t'($bits(in_t)'({$urandom, $urandom}));
					if ($urandom_range(0, 1)) x.packet_pid = cur_pid;
					x.scrambled = ($urandom_range(0, 3) == 0);
					send_byte(x, burst);
				end
			end
		end
	endtask

	initial begin : main
		logic [7:0] p [$];
		logic [7:0] q [$];
		cycle_count = 0;
		stim_done = 0;
		rx_stall_en = 1;
		items_sent = 0;
		sb = new();
		cur_pid = TABLE_PID_RST;
		arst_n = 0;
		cfg_valid = 0;
		cfg_table_pid = 0;
		in_valid = 0;
		in_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: compare with nothing stored, then a good parse and compares
		p = '{8'h00, TABLE_ID_CAT, 8'hF0, 8'd17, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
			8'h09, 8'd6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hAA,
			8'hDE, 8'hAD, 8'hBE, 8'hEF};
		send_packet(p, 8'(p.size()), OP_COMPARE, cur_pid, 0, 0);
		send_packet(p, 8'(p.size()), OP_PARSE, cur_pid, 0, 0);
		send_packet(p, 8'(p.size()), OP_COMPARE, cur_pid, 0, 1);
		q = p; q[16] = 8'h55;
		send_packet(q, 8'(q.size()), OP_COMPARE, cur_pid, 0, 0);
		// bad table id, section number, last section, short section, too-short descriptor
		q = p; q[1] = 8'h02; send_packet(q, 8'(q.size()), OP_PARSE, cur_pid, 0, 1);
		q = p; q[7] = 8'h01; send_packet(q, 8'(q.size()), OP_PARSE, cur_pid, 0, 1);
		q = p; q[8] = 8'h01; send_packet(q, 8'(q.size()), OP_PARSE, cur_pid, 0, 1);
		q = p; q[3] = 8'd5; send_packet(q, 8'(q.size()), OP_PARSE, cur_pid, 0, 1);
		q = p; q[10] = 8'd2; send_packet(q, 8'(q.size()), OP_PARSE, cur_pid, 0, 1);
		// spans packets, unfinished section
		send_packet(p, 8'd10, OP_PARSE, cur_pid, 0, 1);
		q = p; q = q[0:12]; send_packet(q, 8'(p.size()), OP_PARSE, cur_pid, 0, 1);
		// too many descriptors
		build_section(p, DMAX + 1, 0, 0);
		send_packet(p, 8'(p.size()), OP_PARSE, cur_pid, 0, 1);
		// overlong packet
		build_section(p, 2, 0, 0);
		while (p.size() < PMAX + 3) p.push_back(8'hFF);
		send_packet(p, 8'd255, OP_PARSE, cur_pid, 0, 1);
		send_packet(p, 8'd255, OP_COMPARE, cur_pid, 0, 1);

		// Register extremes and random phases
		write_pid(13'd0);
		run_random(900);
		write_pid(13'h1FFF);
		run_random(1100);
		// pause until all results have come, then run with the receiver never stalling
		wait_drain();
		rx_stall_en = 0;
		run_random(1300);
		rx_stall_en = 1;
		write_pid(13'($urandom_range(1, 8190)));
		run_random(1550);
		write_pid(TABLE_PID_RST);
		run_random(1750);

		wait_drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[files.f]
hdl/tscat_pkg.sv
hdl/tscat_ram.sv
hdl/tscat_front.sv
hdl/tscat_back.sv
hdl/ts_cat_section_parser_unit.sv
bench/ts_cat_section_parser_unit_tb.sv
